// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i, one quiet in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clk_i edge outside reset.
`define SRMS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check a property at every rising clk_i edge, reset included.
`define SRMS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

// ===== hdl/srms_pkg.sv =====
// ----------------------------------------------------------------------------
// srms_pkg
// Types and constants of the scaled sparse row matrix-vector block.
// ----------------------------------------------------------------------------
`default_nettype none

package srms_pkg;

  localparam int unsigned X_DEPTH_DEF = 1024;

  localparam logic [31:0] ALPHA_RESET = 32'h0001_0000;
  localparam logic [31:0] BETA_RESET  = 32'h0000_0000;
  localparam logic [15:0] ROWS_RESET  = 16'd1;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_NZ    = 2'd1,
    OP_EMPTY = 2'd2
  } srms_op_e;

  typedef enum logic [1:0] {
    REG_ALPHA = 2'd0,
    REG_BETA  = 2'd1,
    REG_ROWS  = 2'd2
  } srms_reg_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [9:0]         column_index;
    logic signed [31:0] data_value;
    logic               row_ends;
    logic signed [31:0] old_row_value;
  } srms_in_t;

  typedef struct packed {
    logic signed [31:0] row_result;
    logic [15:0]        row_number;
    logic               last_row;
    logic               saturated;
  } srms_out_t;

  typedef struct packed {
    logic cap_in;
    logic mem_wr;
    logic mem_rd;
    logic mul_en;
    logic acc_en;
    logic scale_en;
    logic out_load;
  } srms_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       row_ends;
    logic       out_free;
  } srms_sts_t;

endpackage

`default_nettype wire

// ===== hdl/srms_ctrl.sv =====
// ----------------------------------------------------------------------------
// srms_ctrl
// Sequencer: steps each item through index reduction and then, by opcode, vector
// store access, multiply, accumulate, scaling and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module srms_ctrl
  import srms_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire srms_sts_t sts_i,
  output srms_cmd_t      cmd_o
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b000_0001,
    ST_RED   = 7'b000_0010,
    ST_MEM   = 7'b000_0100,
    ST_MUL   = 7'b000_1000,
    ST_ACC   = 7'b001_0000,
    ST_SCALE = 7'b010_0000,
    ST_SUM   = 7'b100_0000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap_in = 1'b1;
          state_d      = ST_RED;
        end
      end
      ST_RED: begin
        unique case (sts_i.op) inside
          OP_LOAD, OP_NZ: state_d = ST_MEM;
          OP_EMPTY:       state_d = ST_SCALE;
          default:        state_d = ST_IDLE;
        endcase
      end
      ST_MEM: begin
        if (sts_i.op == OP_LOAD) begin
          cmd_o.mem_wr = 1'b1;
          state_d      = ST_IDLE;
        end else begin
          cmd_o.mem_rd = 1'b1;
          state_d      = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc_en = 1'b1;
        state_d      = sts_i.row_ends ? ST_SCALE : ST_IDLE;
      end
      ST_SCALE: begin
        cmd_o.scale_en = 1'b1;
        state_d        = ST_SUM;
      end
      ST_SUM: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `SRMS_ASSERT(a_accept_then_busy, (in_valid_i && !in_stall_o) |=> in_stall_o,
               "controller took an item without going busy")
  `SRMS_ASSERT(a_result_needs_slot, cmd_o.out_load |-> sts_i.out_free,
               "result loaded into an occupied output register")

endmodule

`default_nettype wire

// ===== hdl/srms_dp.sv =====
// ----------------------------------------------------------------------------
// srms_dp
// Datapath: configuration registers, vector store, product, saturating
// row accumulator, alpha/beta scaling and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module srms_dp
  import srms_pkg::*;
#(
  parameter int unsigned X_DEPTH = X_DEPTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire srms_in_t    in_data_i,
  input  wire srms_cmd_t   cmd_i,
  output srms_sts_t        sts_o,
  input  wire logic        out_stall_i,
  output logic             out_valid_o,
  output srms_out_t        out_data_o
);

  localparam int unsigned AW       = $clog2(X_DEPTH);
  localparam int unsigned RECIP_SH = 20;
  localparam logic [19:0] RECIP    = 20'((64'd1 << RECIP_SH) / X_DEPTH);
  localparam logic [16:0] DEPTH_C  = 17'(X_DEPTH);

  logic signed [31:0] alpha_q, beta_q;
  logic [15:0]        rows_q;

  srms_in_t           in_q;
  logic [9:0]         quo_q;
  logic [29:0]        quo_prod;
  logic [26:0]        back_prod;
  logic [9:0]         rem_raw, rem_fix;
  logic [AW-1:0]      addr;
  logic [31:0]        x_mem [X_DEPTH];
  logic signed [31:0] x_rd_q;

  logic signed [63:0] prod_q, prod_d;
  logic signed [64:0] acc_sum;
  logic signed [63:0] acc_q, acc_d;

  logic signed [31:0] acc_hi;
  logic signed [32:0] acc_lo, alpha_x;
  logic signed [63:0] ah_q, ah_d, al_q, al_d, by_q, by_d;
  logic signed [64:0] al_rnd, by_rnd;
  logic signed [65:0] total;
  logic [34:0]        total_top;
  logic               sat;
  logic signed [31:0] clip;

  logic [15:0]        row_cnt_q;
  logic [15:0]        row_lim;
  logic               last_d;
  logic               out_valid_q;
  srms_out_t          out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= ALPHA_RESET;
      beta_q  <= BETA_RESET;
      rows_q  <= ROWS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ALPHA: alpha_q <= cfg_wdata_i;
        REG_BETA:  beta_q  <= cfg_wdata_i;
        REG_ROWS:  rows_q  <= cfg_wdata_i[15:0];
        default:   ;
      endcase
    end
  end

  // column modulo depth: reciprocal estimate, then one correction
  assign quo_prod  = {20'd0, in_q.column_index} * {10'd0, RECIP};
  assign back_prod = {17'd0, quo_q} * {10'd0, DEPTH_C};
  assign rem_raw   = in_q.column_index - back_prod[9:0];
  assign rem_fix   = ({7'd0, rem_raw} >= DEPTH_C) ? (rem_raw - DEPTH_C[9:0]) : rem_raw;
  assign addr      = AW'(rem_fix);

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      in_q <= in_data_i;
    end
    quo_q <= quo_prod[29:20];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr) begin
      x_mem[addr] <= in_q.data_value;
    end
    if (cmd_i.mem_rd) begin
      x_rd_q <= x_mem[addr];
    end
  end

  assign prod_d  = in_q.data_value * x_rd_q;
  assign acc_sum = {acc_q[63], acc_q} + {prod_q[63], prod_q};

  always_comb begin
    if (acc_sum[64] != acc_sum[63]) begin
      acc_d = acc_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      acc_d = acc_sum[63:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
  end

  assign acc_hi  = acc_q[63:32];
  assign acc_lo  = {1'b0, acc_q[31:0]};
  assign alpha_x = {alpha_q[31], alpha_q};
  assign ah_d    = alpha_q * acc_hi;
  assign al_d    = 64'(alpha_x * acc_lo);
  assign by_d    = beta_q * in_q.old_row_value;

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale_en) begin
      ah_q <= ah_d;
      al_q <= al_d;
      by_q <= by_d;
    end
  end

  assign al_rnd = {al_q[63], al_q} + 65'sd2147483648;
  assign by_rnd = {by_q[63], by_q} + 65'sd32768;
  assign total  = {{2{ah_q[63]}}, ah_q}
                + {{33{al_rnd[64]}}, al_rnd[64:32]}
                + {{17{by_rnd[64]}}, by_rnd[64:16]};

  assign total_top = total[65:31];
  assign sat       = !((&total_top) || (~|total_top));
  assign clip      = sat ? (total[65] ? 32'h8000_0000 : 32'h7FFF_FFFF) : total[31:0];

  assign row_lim = (rows_q == 16'd0) ? 16'd0 : (rows_q - 16'd1);
  assign last_d  = (row_cnt_q >= row_lim);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      row_cnt_q <= '0;
    end else if (cmd_i.out_load) begin
      acc_q     <= '0;
      row_cnt_q <= last_d ? 16'd0 : (row_cnt_q + 16'd1);
    end else if (cmd_i.acc_en) begin
      acc_q     <= acc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.row_result <= clip;
      out_q.row_number <= row_cnt_q;
      out_q.last_row   <= last_d;
      out_q.saturated  <= sat;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;
  assign sts_o.op        = in_q.opcode;
  assign sts_o.row_ends  = in_q.row_ends;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  `SRMS_ASSERT_ALWAYS(a_mem_one_port, !(cmd_i.mem_wr && cmd_i.mem_rd),
                      "vector store read and written in one cycle")
  `SRMS_ASSERT(a_result_shown, cmd_i.out_load |=> out_valid_o,
               "loaded result not presented")
  `SRMS_ASSERT(a_row_closed, cmd_i.out_load |=> (acc_q == 64'sd0),
               "accumulator not cleared after closing a row")
  `SRMS_ASSERT(a_last_wraps, (cmd_i.out_load && last_d) |=> (row_cnt_q == 16'd0),
               "row counter did not wrap after the last row")

endmodule

`default_nettype wire

// ===== hdl/sparse_row_matvec_scaled.sv =====
// Computes y = alpha*A*x + beta*y over a compressed-row stream, one item at a
// time. Load items pass capture, column reduction and store write; nonzeros
// read the store instead, then multiply and accumulate. Row-ending nonzeros and
// empty-row items (no store access) take the row close too: it registers the
// scaling products and, once no earlier result is still held in the output
// register, loads the clipped 66-bit rounding sum there. The vector store holds
// X_DEPTH words with no reset; column indexes are taken modulo X_DEPTH. The
// user must make configuration writes only while the block idles (unenforced).
// ----------------------------------------------------------------------------
// sparse_row_matvec_scaled
// Top level: sequencer and datapath of the scaled sparse matrix-vector block.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_row_matvec_scaled
  import srms_pkg::*;
#(
  parameter int unsigned X_DEPTH = X_DEPTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire srms_in_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output srms_out_t        out_data_o
);

  srms_cmd_t cmd;
  srms_sts_t sts;

  srms_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  srms_dp #(
    .X_DEPTH (X_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== verif/sparse_row_matvec_scaled_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_row_matvec_scaled_checker
// Watches the configuration port and both item channels of the scaled sparse
// matrix-vector block. Mirrors its registers, vector store, row sum and row
// counter. Predicts each row result and compares it field by field, in order.
// ----------------------------------------------------------------------------

module sparse_row_matvec_scaled_checker
  import srms_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  srms_in_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  srms_out_t   out_data_i,
  output int          rows_due_o,
  output int          mismatches_o
);

  localparam logic signed [63:0]  ACC_MAX    = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0]  ACC_MIN    = {1'b1, {63{1'b0}}};
  localparam logic signed [127:0] HALF_Q32   = 128'sd2147483648;
  localparam logic signed [127:0] HALF_Q16   = 128'sd32768;
  localparam logic signed [127:0] RESULT_MAX = 128'sd2147483647;
  localparam logic signed [127:0] RESULT_MIN = -128'sd2147483648;
  localparam int                  MAX_REPORTS = 10;

  logic signed [31:0] alpha_q;
  logic signed [31:0] beta_q;
  logic [15:0]        rows_q;
  logic [15:0]        row_ctr;
  logic signed [63:0] row_sum;
  logic signed [31:0] x_vec [X_DEPTH_DEF];
  srms_out_t          rows_expected [$];

  task automatic absorb_item(input srms_in_t item);
    logic signed [63:0]  product;
    logic signed [64:0]  acc_sum;
    logic signed [127:0] alpha_term;
    logic signed [127:0] beta_term;
    logic signed [127:0] total;
    logic [15:0]         final_row;
    logic                closes;
    srms_out_t           row;
    closes = 1'b0;
    case (item.opcode)
      OP_LOAD: x_vec[item.column_index] = $signed(item.data_value);
      OP_NZ: begin
        product = $signed(item.data_value) * x_vec[item.column_index];
        acc_sum = row_sum + product;
        if (acc_sum[64] != acc_sum[63]) begin
          row_sum = acc_sum[64] ? ACC_MIN : ACC_MAX;
        end else begin
          row_sum = acc_sum[63:0];
        end
        closes = item.row_ends;
      end
      OP_EMPTY: closes = 1'b1;
      default: ;
    endcase
    if (closes) begin
      alpha_term = ($signed(alpha_q) * row_sum + HALF_Q32) >>> 32;
      beta_term  = ($signed(beta_q) * $signed(item.old_row_value) + HALF_Q16) >>> 16;
      total      = alpha_term + beta_term;
      row.saturated = 1'b0;
      if (total > RESULT_MAX) begin
        total = RESULT_MAX;
        row.saturated = 1'b1;
      end else if (total < RESULT_MIN) begin
        total = RESULT_MIN;
        row.saturated = 1'b1;
      end
      final_row      = (rows_q == 16'd0) ? 16'd0 : rows_q - 16'd1;
      row.row_result = total[31:0];
      row.row_number = row_ctr;
      row.last_row   = (row_ctr >= final_row);
      row_ctr        = row.last_row ? 16'd0 : row_ctr + 16'd1;
      row_sum        = '0;
      rows_expected.push_back(row);
      rows_due_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    srms_out_t want;
    if (!rst_ni) begin
      alpha_q      = ALPHA_RESET;
      beta_q       = BETA_RESET;
      rows_q       = ROWS_RESET;
      row_ctr      = '0;
      row_sum      = '0;
      rows_expected.delete();
      rows_due_o   = 0;
      mismatches_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ALPHA: alpha_q = cfg_wdata_i;
          REG_BETA:  beta_q  = cfg_wdata_i;
          REG_ROWS:  rows_q  = cfg_wdata_i[15:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (rows_expected.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= MAX_REPORTS) begin
            $display("%0t: unexpected row item: result %h row %0d last %b sat %b", $realtime,
                     out_data_i.row_result, out_data_i.row_number, out_data_i.last_row,
                     out_data_i.saturated);
          end
        end else begin
          want = rows_expected.pop_front();
          rows_due_o--;
          if (want.row_result !== out_data_i.row_result ||
              want.row_number !== out_data_i.row_number ||
              want.last_row   !== out_data_i.last_row ||
              want.saturated  !== out_data_i.saturated) begin
            mismatches_o++;
            if (mismatches_o <= MAX_REPORTS) begin
              $display("%0t: row mismatch: expected result %h row %0d last %b sat %b", $realtime,
                       want.row_result, want.row_number, want.last_row, want.saturated);
              $display("%0t:               actual   result %h row %0d last %b sat %b", $realtime,
                       out_data_i.row_result, out_data_i.row_number, out_data_i.last_row,
                       out_data_i.saturated);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        absorb_item(in_data_i);
      end
    end
  end

endmodule

// ===== verif/sparse_row_matvec_scaled_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_row_matvec_scaled_test
// Drives the scaled sparse matrix-vector block with directed corner items and
// then with random compressed-row matrices over several register settings,
// with random idling on both channels and a long receiver hold-off. A
// separate checker predicts and compares every row result.
// ----------------------------------------------------------------------------

module sparse_row_matvec_scaled_test;
  import srms_pkg::*;

  localparam logic [1:0]  OP_SPARE      = 2'd3;
  localparam logic [1:0]  REG_SPARE     = 2'd3;
  localparam logic [31:0] Q_ONE         = 32'h0001_0000;
  localparam int          ITEM_TARGET   = 2000;
  localparam int          QUIET_ITEMS   = 200;
  localparam int          SETTLE_CYCLES = 24;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          HOLD_PHASE    = 2;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [31:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  srms_in_t    in_data;
  logic        out_valid;
  logic        out_stall;
  srms_out_t   out_data;
  int          rows_due;
  int          mismatches;

  int          items_sent = 0;
  int          gap_pct = 20;
  int          stall_pct = 20;
  bit          hold_req = 1'b0;
  bit          x_loaded [X_DEPTH_DEF];
  int          loaded_cols [$];

  sparse_row_matvec_scaled i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  sparse_row_matvec_scaled_checker i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .rows_due_o  (rows_due),
    .mismatches_o(mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic srms_in_t make_item(input logic [1:0] op, input logic [9:0] col,
                                         input logic [31:0] val, input logic ends,
                                         input logic [31:0] old_y);
    srms_in_t item;
    item.opcode        = op;
    item.column_index  = col;
    item.data_value    = val;
    item.row_ends      = ends;
    item.old_row_value = old_y;
    return item;
  endfunction

  function automatic logic [31:0] rand_q();
    logic [31:0] v;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'h0000_0000;
          3: v = Q_ONE;
          default: v = 32'hFFFF_0000;
        endcase
      end
      1, 2: v = $urandom;
      default: v = 32'($urandom_range(0, 32'h001F_FFFF)) - 32'h0010_0000;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] rand_scale();
    case ($urandom_range(0, 3))
      0: return Q_ONE;
      1: return 32'h0000_0000;
      default: return rand_q();
    endcase
  endfunction

  function automatic int idle_pct();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 10;
      default: return 35;
    endcase
  endfunction

  task automatic offer_item(input srms_in_t item);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    if (item.opcode == OP_LOAD && !x_loaded[item.column_index]) begin
      x_loaded[item.column_index] = 1'b1;
      loaded_cols.push_back(item.column_index);
    end
    if (item.opcode != OP_SPARE) items_sent++;
    if (items_sent >= ITEM_TARGET - QUIET_ITEMS) begin
      gap_pct   = 0;
      stall_pct = 0;
    end
  endtask

  task automatic drain_rows();
    in_valid <= 1'b0;
    @(posedge clk);
    while (rows_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] alpha, input logic [31:0] beta,
                            input logic [15:0] rows, input bit touch_spare);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_ALPHA;
    cfg_wdata <= alpha;
    @(posedge clk);
    cfg_idx   <= REG_BETA;
    cfg_wdata <= beta;
    @(posedge clk);
    cfg_idx   <= REG_ROWS;
    cfg_wdata <= {16'($urandom), rows};
    @(posedge clk);
    if (touch_spare) begin
      cfg_idx   <= REG_SPARE;
      cfg_wdata <= $urandom;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    int stall_left;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(1, 17) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int          phase;
    int          nonzeros;
    logic [15:0] rows_pick;
    logic [9:0]  col;
    rst_n = 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_idx   <= '0;
    cfg_wdata <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_config(Q_ONE, 32'h0000_0000, 16'd4, 1'b1);
    offer_item(make_item(OP_LOAD, 10'd0, 32'h7FFF_FFFF, 1'b1, 32'h5555_5555));
    offer_item(make_item(OP_LOAD, 10'd1023, 32'h8000_0000, 1'b0, 32'hAAAA_AAAA));
    offer_item(make_item(OP_LOAD, 10'd5, Q_ONE, 1'b0, 32'h0000_0000));
    offer_item(make_item(OP_LOAD, 10'd512, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF));
    offer_item(make_item(OP_NZ, 10'd5, 32'h0002_0000, 1'b1, 32'h1234_5678));
    offer_item(make_item(OP_NZ, 10'd0, 32'h7FFF_FFFF, 1'b0, 32'hFFFF_FFFF));
    offer_item(make_item(OP_NZ, 10'd0, 32'h7FFF_FFFF, 1'b0, 32'h0000_0000));
    offer_item(make_item(OP_NZ, 10'd1023, 32'h8000_0000, 1'b1, 32'h7FFF_FFFF));
    offer_item(make_item(OP_SPARE, 10'd1023, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF));
    offer_item(make_item(OP_EMPTY, 10'd0, 32'h0000_0000, 1'b0, 32'h7FFF_FFFF));
    offer_item(make_item(OP_NZ, 10'd512, 32'h8000_0000, 1'b1, 32'h8000_0000));
    drain_rows();

    set_config(32'h8000_0000, 32'h7FFF_FFFF, 16'd0, 1'b0);
    offer_item(make_item(OP_EMPTY, 10'd1023, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000));
    offer_item(make_item(OP_NZ, 10'd1023, 32'h8000_0000, 1'b1, 32'h7FFF_FFFF));
    offer_item(make_item(OP_NZ, 10'd5, Q_ONE, 1'b0, Q_ONE));
    offer_item(make_item(OP_EMPTY, 10'd0, 32'h0000_0000, 1'b0, Q_ONE));
    drain_rows();

    set_config(32'h7FFF_FFFF, 32'h8000_0000, 16'd3, 1'b0);
    offer_item(make_item(OP_NZ, 10'd0, 32'h8000_0000, 1'b1, 32'h8000_0000));
    offer_item(make_item(OP_EMPTY, 10'd512, 32'h0000_0000, 1'b0, 32'h7FFF_FFFF));
    drain_rows();

    set_config(Q_ONE, 32'h0000_0000, 16'd1, 1'b0);
    offer_item(make_item(OP_EMPTY, 10'd1023, 32'h0000_0000, 1'b0, 32'hFFFF_FFFF));
    offer_item(make_item(OP_NZ, 10'd1023, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000));

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      drain_rows();
      if (items_sent >= ITEM_TARGET - QUIET_ITEMS) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = idle_pct();
        stall_pct = idle_pct();
      end
      case ($urandom_range(0, 5))
        0: rows_pick = 16'd0;
        1: rows_pick = 16'hFFFF;
        2: rows_pick = 16'd1;
        default: rows_pick = 16'($urandom_range(2, 12));
      endcase
      set_config(rand_scale(), rand_scale(), rows_pick, $urandom_range(0, 3) == 0);
      repeat ($urandom_range(4, 40)) begin
        offer_item(make_item(OP_LOAD, 10'($urandom), rand_q(), 1'($urandom), $urandom));
      end
      if (phase == HOLD_PHASE) begin
        gap_pct  = 0;
        hold_req = 1'b1;
      end
      repeat ($urandom_range(2, 30)) begin
        nonzeros = $urandom_range(0, 5);
        if (nonzeros == 0) begin
          offer_item(make_item(OP_EMPTY, 10'($urandom), $urandom, 1'($urandom), rand_q()));
        end
        for (int k = 0; k < nonzeros; k++) begin
          // drop in noise and broken rows now and then
          case ($urandom_range(0, 39))
            0: offer_item(make_item(OP_SPARE, 10'($urandom), $urandom, 1'($urandom), $urandom));
            1: offer_item(make_item(OP_LOAD, 10'($urandom), rand_q(), 1'($urandom), $urandom));
            2: offer_item(make_item(OP_EMPTY, 10'($urandom), $urandom, 1'($urandom), rand_q()));
            default: ;
          endcase
          col = 10'(loaded_cols[$urandom_range(0, loaded_cols.size() - 1)]);
          offer_item(make_item(OP_NZ, col, rand_q(), k == nonzeros - 1, rand_q()));
        end
      end
      phase++;
    end
    drain_rows();

    if (mismatches == 0 && rows_due == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
